/* rtl/paf_pkg.sv */
// ----------------------------------------------------------------------------
// paf_pkg
// Shared widths, codes and control structs of the paged frame allocator.
// ----------------------------------------------------------------------------
package paf_pkg;

	// default table sizes
	localparam int NUM_FRAMES_DEF   = 64;
	localparam int MAX_RESIDENT_DEF = 16;

	// fixed field widths
	localparam int KIND_W    = 2;
	localparam int PID_W     = 16;
	localparam int NEED_W    = 7;
	localparam int BYTES_W   = 32;
	localparam int STAT_W    = 2;
	localparam int CNT_OUT_W = 7;
	localparam int TOT_W     = 32;

	// request kinds
	localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

	// result status codes
	localparam logic [STAT_W-1:0] RES_DONE    = 2'd0;
	localparam logic [STAT_W-1:0] RES_NOFRAME = 2'd1;
	localparam logic [STAT_W-1:0] RES_FULL    = 2'd2;

	// datapath operations
	localparam int OP_W = 4;
	localparam logic [OP_W-1:0] OP_NOP   = 4'd0;
	localparam logic [OP_W-1:0] OP_LOAD  = 4'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 4'd2;
	localparam logic [OP_W-1:0] OP_ASTEP = 4'd3;
	localparam logic [OP_W-1:0] OP_REC   = 4'd4;
	localparam logic [OP_W-1:0] OP_RSTEP = 4'd5;
	localparam logic [OP_W-1:0] OP_FSTEP = 4'd6;
	localparam logic [OP_W-1:0] OP_TALLY = 4'd7;
	localparam logic [OP_W-1:0] OP_FIN   = 4'd8;

	// controller to datapath
	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [STAT_W-1:0] res;
	} paf_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              need_zero;
		logic              short_frames;
		logic              table_full;
		logic              res_empty;
		logic              alloc_last;
		logic              rscan_last;
		logic              fscan_last;
		logic              out_busy;
	} paf_stat_t;

endpackage

/* rtl/paged_frame_allocator.sv */
// ----------------------------------------------------------------------------
// paged_frame_allocator
// Frame ownership table with first-fit allocate, free by pid and query.
// ----------------------------------------------------------------------------
// One request is processed at a time and gives exactly one result. The frame
// owner table and the resident table are RAMs walked one entry per cycle, so
// the request time is set by those scans: allocate walks the frames up to the
// last frame it takes (at most NUM_FRAMES); free walks the resident entries,
// skipped with an empty resident table, and then all NUM_FRAMES frames; query
// walks all NUM_FRAMES frames; a refused allocate or an unused kind walks no
// table. A new request
// may be accepted while the previous result still waits on the output; it
// completes only once that result has been taken. No clearing pass is needed
// after reset: frame valid bits and the resident count reset directly.
// ----------------------------------------------------------------------------
module paged_frame_allocator import paf_pkg::*; #(
	parameter int NUM_FRAMES   = NUM_FRAMES_DEF,
	parameter int MAX_RESIDENT = MAX_RESIDENT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [KIND_W-1:0]    kind,
	input  logic [PID_W-1:0]     pid,
	input  logic [NEED_W-1:0]    pages_needed,
	input  logic [BYTES_W-1:0]   memory_bytes,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [STAT_W-1:0]    status,
	output logic                 allocated,
	output logic [CNT_OUT_W-1:0] frames_changed,
	output logic [CNT_OUT_W-1:0] free_frames,
	output logic [TOT_W-1:0]     used_bytes,
	output logic [TOT_W-1:0]     pages_in_total,
	output logic [TOT_W-1:0]     pages_out_total
);

	paf_cmd_t  cmd;
	paf_stat_t stat;

	// sequencer
	paf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	// tables, totals and result register
	paf_dp #(
		.NUM_FRAMES  (NUM_FRAMES),
		.MAX_RESIDENT(MAX_RESIDENT)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.kind           (kind),
		.pid            (pid),
		.pages_needed   (pages_needed),
		.memory_bytes   (memory_bytes),
		.out_ready      (out_ready),
		.cmd            (cmd),
		.stat           (stat),
		.out_valid      (out_valid),
		.status         (status),
		.allocated      (allocated),
		.frames_changed (frames_changed),
		.free_frames    (free_frames),
		.used_bytes     (used_bytes),
		.pages_in_total (pages_in_total),
		.pages_out_total(pages_out_total)
	);

endmodule

/* rtl/paf_ram.sv */
// ----------------------------------------------------------------------------
// paf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module paf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/paf_dp.sv */
// ----------------------------------------------------------------------------
// paf_dp
// Datapath: frame and resident tables, scan pipelines, totals, output register.
// ----------------------------------------------------------------------------
module paf_dp import paf_pkg::*; #(
	parameter int NUM_FRAMES   = NUM_FRAMES_DEF,
	parameter int MAX_RESIDENT = MAX_RESIDENT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [KIND_W-1:0]    kind,
	input  logic [PID_W-1:0]     pid,
	input  logic [NEED_W-1:0]    pages_needed,
	input  logic [BYTES_W-1:0]   memory_bytes,
	input  logic                 out_ready,
	input  paf_cmd_t             cmd,
	output paf_stat_t            stat,
	output logic                 out_valid,
	output logic [STAT_W-1:0]    status,
	output logic                 allocated,
	output logic [CNT_OUT_W-1:0] frames_changed,
	output logic [CNT_OUT_W-1:0] free_frames,
	output logic [TOT_W-1:0]     used_bytes,
	output logic [TOT_W-1:0]     pages_in_total,
	output logic [TOT_W-1:0]     pages_out_total
);

	localparam int FIDX_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
	localparam int CNT_W  = $clog2(NUM_FRAMES + 1);
	localparam int RIDX_W = (MAX_RESIDENT > 1) ? $clog2(MAX_RESIDENT) : 1;
	localparam int RCNT_W = $clog2(MAX_RESIDENT + 1);
	localparam int CMP_W  = ((CNT_W > NEED_W) ? CNT_W : NEED_W) + 1;
	localparam int RES_W  = PID_W + BYTES_W;

	// latched request
	logic [KIND_W-1:0]  kind_q;
	logic [PID_W-1:0]   pid_q;
	logic [NEED_W-1:0]  need_q;
	logic [BYTES_W-1:0] bytes_q;

	// table state and totals
	logic [NUM_FRAMES-1:0] used_q;
	logic [CNT_W-1:0]      free_cnt_q;
	logic [RCNT_W-1:0]     res_cnt_q;
	logic [TOT_W-1:0]      used_total_q;
	logic [TOT_W-1:0]      pin_q;
	logic [TOT_W-1:0]      pout_q;

	// per-request work registers
	logic [CNT_W-1:0]  changed_q;
	logic              held_q;
	logic              found_q;
	logic [CNT_W-1:0]  fidx_q;
	logic [RCNT_W-1:0] ridx_q;
	logic [RCNT_W-1:0] w_q;
	logic              fv_s1;
	logic [FIDX_W-1:0] fidx_s1;
	logic              rv_s1;
	logic [RIDX_W-1:0] ridx_s1;

	// output register
	logic                 out_valid_q;
	logic [STAT_W-1:0]    status_q;
	logic                 allocated_q;
	logic [CNT_OUT_W-1:0] changed_out_q;
	logic [CNT_OUT_W-1:0] free_out_q;
	logic [TOT_W-1:0]     used_out_q;
	logic [TOT_W-1:0]     pin_out_q;
	logic [TOT_W-1:0]     pout_out_q;

	logic [FIDX_W-1:0]  fidx;
	logic [RIDX_W-1:0]  ridx;
	logic               f_issue;
	logic               r_issue;
	logic [PID_W-1:0]   owner_rd;
	logic [RES_W-1:0]   res_rd;
	logic [PID_W-1:0]   res_pid_rd;
	logic [BYTES_W-1:0] res_bytes_rd;
	logic               r_match;
	logic               f_hit;
	logic               a_take;
	logic               owner_we;
	logic               res_we;
	logic [RIDX_W-1:0]  res_waddr;
	logic [RES_W-1:0]   res_wdata;

	// scan addressing and compares
	assign fidx         = fidx_q[FIDX_W-1:0];
	assign ridx         = ridx_q[RIDX_W-1:0];
	assign f_issue      = (cmd.op == OP_FSTEP) && (fidx_q < CNT_W'(NUM_FRAMES));
	assign r_issue      = (cmd.op == OP_RSTEP) && (ridx_q < res_cnt_q);
	assign res_pid_rd   = res_rd[RES_W-1:BYTES_W];
	assign res_bytes_rd = res_rd[BYTES_W-1:0];
	assign r_match      = (res_pid_rd == pid_q);
	assign f_hit        = fv_s1 && used_q[fidx_s1] && (owner_rd == pid_q);
	assign a_take       = !used_q[fidx];

	// memory write control
	assign owner_we  = (cmd.op == OP_ASTEP) && a_take;
	assign res_we    = (cmd.op == OP_REC) || ((cmd.op == OP_RSTEP) && rv_s1 && !r_match);
	assign res_waddr = (cmd.op == OP_REC) ? res_cnt_q[RIDX_W-1:0] : w_q[RIDX_W-1:0];
	assign res_wdata = (cmd.op == OP_REC) ? {pid_q, bytes_q} : res_rd;

	// frame owner table
	paf_ram #(
		.WIDTH(PID_W),
		.DEPTH(NUM_FRAMES)
	) u_owner_ram (
		.clk  (clk),
		.we   (owner_we),
		.waddr(fidx),
		.wdata(pid_q),
		.raddr(fidx),
		.rdata(owner_rd)
	);

	// resident table, pid above byte size
	paf_ram #(
		.WIDTH(RES_W),
		.DEPTH(MAX_RESIDENT)
	) u_res_ram (
		.clk  (clk),
		.we   (res_we),
		.waddr(res_waddr),
		.wdata(res_wdata),
		.raddr(ridx),
		.rdata(res_rd)
	);

	// status toward the controller
	always_comb begin
		stat.kind         = kind_q;
		stat.need_zero    = (need_q == '0);
		stat.short_frames = CMP_W'(free_cnt_q) < CMP_W'(need_q);
		stat.table_full   = (res_cnt_q == RCNT_W'(MAX_RESIDENT));
		stat.res_empty    = (res_cnt_q == '0);
		stat.alloc_last   = a_take && (CMP_W'(changed_q) + CMP_W'(1) == CMP_W'(need_q));
		stat.rscan_last   = rv_s1 && (RCNT_W'(ridx_s1) + RCNT_W'(1) == res_cnt_q);
		stat.fscan_last   = fv_s1 && (fidx_s1 == FIDX_W'(NUM_FRAMES - 1));
		stat.out_busy     = out_valid_q && !out_ready;
	end

	// request latch, scan stage indexes and output payload
	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD) begin
			kind_q  <= kind;
			pid_q   <= pid;
			need_q  <= pages_needed;
			bytes_q <= memory_bytes;
		end
		fidx_s1 <= fidx;
		ridx_s1 <= ridx;
		if (cmd.op == OP_FIN) begin
			status_q      <= cmd.res;
			allocated_q   <= held_q;
			changed_out_q <= CNT_OUT_W'(changed_q);
			free_out_q    <= CNT_OUT_W'(free_cnt_q);
			used_out_q    <= used_total_q;
			pin_out_q     <= pin_q;
			pout_out_q    <= pout_q;
		end
	end

	// table state, totals and scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q       <= '0;
			free_cnt_q   <= CNT_W'(NUM_FRAMES);
			res_cnt_q    <= '0;
			used_total_q <= '0;
			pin_q        <= '0;
			pout_q       <= '0;
			changed_q    <= '0;
			held_q       <= 1'b0;
			found_q      <= 1'b0;
			fidx_q       <= '0;
			ridx_q       <= '0;
			w_q          <= '0;
			fv_s1        <= 1'b0;
			rv_s1        <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			fv_s1 <= f_issue;
			rv_s1 <= r_issue;
			if (f_issue) begin
				fidx_q <= fidx_q + CNT_W'(1);
			end
			if (r_issue) begin
				ridx_q <= ridx_q + RCNT_W'(1);
			end
			unique case (cmd.op)
				OP_CLEAR: begin
					fidx_q    <= '0;
					ridx_q    <= '0;
					w_q       <= '0;
					changed_q <= '0;
					held_q    <= 1'b0;
					found_q   <= 1'b0;
				end
				OP_ASTEP: begin
					// take the frame if free, lowest index first
					if (a_take) begin
						used_q[fidx] <= 1'b1;
						changed_q    <= changed_q + CNT_W'(1);
						free_cnt_q   <= free_cnt_q - CNT_W'(1);
					end
					fidx_q <= fidx_q + CNT_W'(1);
				end
				OP_REC: begin
					res_cnt_q    <= res_cnt_q + RCNT_W'(1);
					used_total_q <= used_total_q + bytes_q;
					pin_q        <= pin_q + TOT_W'(changed_q);
				end
				OP_RSTEP: begin
					// compact the resident table, charge back the oldest match
					if (rv_s1) begin
						if (r_match) begin
							if (!found_q) begin
								used_total_q <= used_total_q - res_bytes_rd;
								found_q      <= 1'b1;
							end
						end else begin
							w_q <= w_q + RCNT_W'(1);
						end
						if (stat.rscan_last) begin
							res_cnt_q <= r_match ? w_q : w_q + RCNT_W'(1);
						end
					end
				end
				OP_FSTEP: begin
					// release or detect frames owned by the pid
					if (f_hit) begin
						if (kind_q == KIND_FREE) begin
							used_q[fidx_s1] <= 1'b0;
							changed_q       <= changed_q + CNT_W'(1);
							free_cnt_q      <= free_cnt_q + CNT_W'(1);
						end else begin
							held_q <= 1'b1;
						end
					end
				end
				OP_TALLY: begin
					pout_q <= pout_q + TOT_W'(changed_q);
				end
				default: begin
				end
			endcase
			if (cmd.op == OP_FIN) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign allocated       = allocated_q;
	assign frames_changed  = changed_out_q;
	assign free_frames     = free_out_q;
	assign used_bytes      = used_out_q;
	assign pages_in_total  = pin_out_q;
	assign pages_out_total = pout_out_q;

`ifndef SYNTHESIS
	// free count tracks the frame valid bits
	a_free_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		int'(free_cnt_q) + $countones(used_q) == NUM_FRAMES)
		else $error("free frame count out of step with frame table");

	// resident count stays within the table
	a_res_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_cnt_q <= RCNT_W'(MAX_RESIDENT))
		else $error("resident count beyond table size");

	// a record is appended only into a free slot
	a_rec_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_REC) |-> (res_cnt_q < RCNT_W'(MAX_RESIDENT)))
		else $error("resident append into a full table");

	// a result is never loaded over one still waiting
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_FIN) |-> !(out_valid_q && !out_ready))
		else $error("result register overwritten");
`endif

endmodule

/* rtl/paf_ctrl.sv */
// ----------------------------------------------------------------------------
// paf_ctrl
// Request sequencer: decides the outcome and steps the datapath scans.
// ----------------------------------------------------------------------------
module paf_ctrl import paf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  paf_stat_t stat,
	output paf_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECIDE = 3'd1;
	localparam logic [2:0] S_ALLOC  = 3'd2;
	localparam logic [2:0] S_REC    = 3'd3;
	localparam logic [2:0] S_RSCAN  = 3'd4;
	localparam logic [2:0] S_FSCAN  = 3'd5;
	localparam logic [2:0] S_TALLY  = 3'd6;
	localparam logic [2:0] S_FIN    = 3'd7;

	logic [2:0]        state_q;
	logic [2:0]        state_nxt;
	logic [STAT_W-1:0] res_q;
	logic [STAT_W-1:0] res_nxt;

	// next state and datapath command
	always_comb begin
		state_nxt = state_q;
		res_nxt   = res_q;
		cmd.op    = OP_NOP;
		cmd.res   = res_q;
		in_ready  = (state_q == S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op    = OP_LOAD;
					state_nxt = S_DECIDE;
				end
			end
			S_DECIDE: begin
				cmd.op  = OP_CLEAR;
				res_nxt = RES_DONE;
				unique case (stat.kind)
					KIND_ALLOC: begin
						priority if (stat.short_frames) begin
							res_nxt   = RES_NOFRAME;
							state_nxt = S_FIN;
						end else if (stat.table_full) begin
							res_nxt   = RES_FULL;
							state_nxt = S_FIN;
						end else if (stat.need_zero) begin
							state_nxt = S_REC;
						end else begin
							state_nxt = S_ALLOC;
						end
					end
					KIND_FREE: begin
						state_nxt = stat.res_empty ? S_FSCAN : S_RSCAN;
					end
					KIND_QUERY: begin
						state_nxt = S_FSCAN;
					end
					default: begin
						state_nxt = S_FIN;
					end
				endcase
			end
			S_ALLOC: begin
				cmd.op = OP_ASTEP;
				if (stat.alloc_last) begin
					state_nxt = S_REC;
				end
			end
			S_REC: begin
				cmd.op    = OP_REC;
				state_nxt = S_FIN;
			end
			S_RSCAN: begin
				cmd.op = OP_RSTEP;
				if (stat.rscan_last) begin
					state_nxt = S_FSCAN;
				end
			end
			S_FSCAN: begin
				cmd.op = OP_FSTEP;
				if (stat.fscan_last) begin
					state_nxt = (stat.kind == KIND_FREE) ? S_TALLY : S_FIN;
				end
			end
			S_TALLY: begin
				cmd.op    = OP_TALLY;
				state_nxt = S_FIN;
			end
			S_FIN: begin
				if (!stat.out_busy) begin
					cmd.op    = OP_FIN;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_q   <= RES_DONE;
		end else begin
			state_q <= state_nxt;
			res_q   <= res_nxt;
		end
	end

`ifndef SYNTHESIS
	// an accepted item always moves on to the decision step
	a_accept_decide: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_DECIDE))
		else $error("accepted item not decided");

	// allocations short of frames skip every scan and report the shortage
	a_fail_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DECIDE && stat.kind == KIND_ALLOC && stat.short_frames)
		|=> (state_q == S_FIN && res_q == RES_NOFRAME))
		else $error("frame shortage not reported");

	// a waiting result holds the sequencer in its final step
	a_fin_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && stat.out_busy) |=> (state_q == S_FIN))
		else $error("sequencer left final step while result pending");
`endif

endmodule

/* sim/paf_checker.sv */
// ----------------------------------------------------------------------------
// paf_checker
// Watches both channels of the paged frame allocator, keeps its own frame
// table and resident list, and compares every result with the prediction.
// ----------------------------------------------------------------------------
module paf_checker import paf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic [KIND_W-1:0]    kind,
	input  logic [PID_W-1:0]     pid,
	input  logic [NEED_W-1:0]    pages_needed,
	input  logic [BYTES_W-1:0]   memory_bytes,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [STAT_W-1:0]    status,
	input  logic                 allocated,
	input  logic [CNT_OUT_W-1:0] frames_changed,
	input  logic [CNT_OUT_W-1:0] free_frames,
	input  logic [TOT_W-1:0]     used_bytes,
	input  logic [TOT_W-1:0]     pages_in_total,
	input  logic [TOT_W-1:0]     pages_out_total,
	output int                   mismatches,
	output int                   outstanding
);

	typedef struct packed {
		logic [STAT_W-1:0]    status;
		logic                 allocated;
		logic [CNT_OUT_W-1:0] frames_changed;
		logic [CNT_OUT_W-1:0] free_frames;
		logic [TOT_W-1:0]     used_bytes;
		logic [TOT_W-1:0]     pages_in_total;
		logic [TOT_W-1:0]     pages_out_total;
	} frame_report_t;

	// shadow frame table and resident list
	logic [PID_W-1:0]          owner_of [NUM_FRAMES_DEF];
	logic [NUM_FRAMES_DEF-1:0] frame_taken;
	logic [PID_W-1:0]          holder_pid [MAX_RESIDENT_DEF];
	logic [BYTES_W-1:0]        holder_bytes [MAX_RESIDENT_DEF];
	int                        holder_count;
	logic [TOT_W-1:0]          bytes_in_use;
	logic [TOT_W-1:0]          paged_in;
	logic [TOT_W-1:0]          paged_out;

	// reports owed by the block, oldest first
	frame_report_t reports_due[$];

	function automatic int free_count();
		int n;
		n = 0;
		for (int i = 0; i < NUM_FRAMES_DEF; i++)
			if (!frame_taken[i])
				n++;
		return n;
	endfunction

	// apply one request to the shadow state and form its report
	function automatic frame_report_t apply_request(logic [KIND_W-1:0] op_kind,
		logic [PID_W-1:0] who, logic [NEED_W-1:0] need, logic [BYTES_W-1:0] size);
		frame_report_t r;
		int moved;
		int kept;
		bit charged;
		r = '0;
		moved = 0;
		case (op_kind)
			KIND_ALLOC: begin
				// a frame shortage wins over a full resident list
				if (free_count() < need)
					r.status = RES_NOFRAME;
				else if (holder_count >= MAX_RESIDENT_DEF)
					r.status = RES_FULL;
				else begin
					for (int i = 0; i < NUM_FRAMES_DEF && moved < need; i++) begin
						if (!frame_taken[i]) begin
							frame_taken[i] = 1'b1;
							owner_of[i] = who;
							moved++;
						end
					end
					paged_in += moved;
					bytes_in_use += size;
					holder_pid[holder_count] = who;
					holder_bytes[holder_count] = size;
					holder_count++;
				end
			end
			KIND_FREE: begin
				// only the oldest entry of the pid is charged back
				charged = 1'b0;
				for (int i = 0; i < holder_count; i++) begin
					if (!charged && holder_pid[i] == who) begin
						bytes_in_use -= holder_bytes[i];
						charged = 1'b1;
					end
				end
				for (int i = 0; i < NUM_FRAMES_DEF; i++) begin
					if (frame_taken[i] && owner_of[i] == who) begin
						frame_taken[i] = 1'b0;
						owner_of[i] = '0;
						moved++;
					end
				end
				paged_out += moved;
				// squeeze out every entry of the pid, keeping arrival order
				kept = 0;
				for (int i = 0; i < holder_count; i++) begin
					if (holder_pid[i] != who) begin
						holder_pid[kept] = holder_pid[i];
						holder_bytes[kept] = holder_bytes[i];
						kept++;
					end
				end
				holder_count = kept;
			end
			KIND_QUERY: begin
				for (int i = 0; i < NUM_FRAMES_DEF; i++)
					if (frame_taken[i] && owner_of[i] == who)
						r.allocated = 1'b1;
			end
			default: ;
		endcase
		r.frames_changed = CNT_OUT_W'(moved);
		r.free_frames = CNT_OUT_W'(free_count());
		r.used_bytes = bytes_in_use;
		r.pages_in_total = paged_in;
		r.pages_out_total = paged_out;
		return r;
	endfunction

	function automatic void check_field(string name, logic [TOT_W-1:0] want,
		logic [TOT_W-1:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endfunction

	// track items in, compare results out
	always @(posedge clk or negedge arst_n) begin
		frame_report_t due;
		if (!arst_n) begin
			for (int i = 0; i < NUM_FRAMES_DEF; i++)
				owner_of[i] = '0;
			for (int i = 0; i < MAX_RESIDENT_DEF; i++) begin
				holder_pid[i] = '0;
				holder_bytes[i] = '0;
			end
			frame_taken = '0;
			holder_count = 0;
			bytes_in_use = '0;
			paged_in = '0;
			paged_out = '0;
			reports_due.delete();
			outstanding = 0;
		end else begin
			// a result always belongs to an earlier item
			if (out_valid && out_ready) begin
				if (reports_due.size() == 0) begin
					mismatches++;
					$display("%0t: result with no item pending, status %0h", $time, status);
				end else begin
					due = reports_due.pop_front();
					check_field("status", due.status, status);
					check_field("allocated", due.allocated, allocated);
					check_field("frames_changed", due.frames_changed, frames_changed);
					check_field("free_frames", due.free_frames, free_frames);
					check_field("used_bytes", due.used_bytes, used_bytes);
					check_field("pages_in_total", due.pages_in_total, pages_in_total);
					check_field("pages_out_total", due.pages_out_total, pages_out_total);
				end
			end
			if (in_valid && in_ready)
				reports_due.insert(reports_due.size(),
					apply_request(kind, pid, pages_needed, memory_bytes));
			outstanding = reports_due.size();
		end
	end

endmodule

/* sim/paged_frame_allocator_test.sv */
// ----------------------------------------------------------------------------
// paged_frame_allocator_test
// Drives directed and random allocate, free, query and unused-kind items into the frame
// allocator with random idling on both channels; a checker alongside predicts
// and compares every result, and this module reports the verdict.
// ----------------------------------------------------------------------------
module paged_frame_allocator_test;
	import paf_pkg::*;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT  = 1_500_000;
	localparam int RANDOM_ITEMS = 1800;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 150;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [KIND_W-1:0]    kind;
	logic [PID_W-1:0]     pid;
	logic [NEED_W-1:0]    pages_needed;
	logic [BYTES_W-1:0]   memory_bytes;
	logic                 out_valid;
	logic                 out_ready;
	logic [STAT_W-1:0]    status;
	logic                 allocated;
	logic [CNT_OUT_W-1:0] frames_changed;
	logic [CNT_OUT_W-1:0] free_frames;
	logic [TOT_W-1:0]     used_bytes;
	logic [TOT_W-1:0]     pages_in_total;
	logic [TOT_W-1:0]     pages_out_total;

	int               fail_count;
	int               waiting;
	int               cycle_count;
	bit               long_hold;
	bit               no_idle;
	logic [PID_W-1:0] pid_pool [6];

	paged_frame_allocator dut (.*);

	paf_checker checker_i (
		.mismatches  (fail_count),
		.outstanding (waiting),
		.*
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// idle length: mostly none or short, now and then long
	function automatic int idle_len();
		int r;
		r = $urandom_range(99, 0);
		if (no_idle || r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(3, 1);
		else if (r < 98)
			return $urandom_range(12, 4);
		else
			return $urandom_range(60, 20);
	endfunction

	// pids mostly from a small pool so that frees and queries hit
	function automatic logic [PID_W-1:0] pick_pid();
		if ($urandom_range(99, 0) < 85)
			return pid_pool[$urandom_range(5, 0)];
		return PID_W'($urandom);
	endfunction

	function automatic logic [NEED_W-1:0] pick_need();
		int r;
		r = $urandom_range(99, 0);
		if (r < 70)
			return NEED_W'($urandom_range(8, 0));
		else if (r < 92)
			return NEED_W'($urandom_range(64, 9));
		else
			return NEED_W'($urandom_range(127, 65));
	endfunction

	function automatic logic [BYTES_W-1:0] pick_bytes();
		int r;
		r = $urandom_range(99, 0);
		if (r < 10)
			return '0;
		else if (r < 20)
			return '1;
		else
			return BYTES_W'($urandom);
	endfunction

	// offer one item, hold it until taken, then maybe idle
	task automatic issue(input logic [KIND_W-1:0] k, input logic [PID_W-1:0] p,
		input logic [NEED_W-1:0] need, input logic [BYTES_W-1:0] size);
		int g;
		@(negedge clk);
		in_valid     <= 1'b1;
		kind         <= k;
		pid          <= p;
		pages_needed <= need;
		memory_bytes <= size;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		g = idle_len();
		if (g > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (g - 1) @(negedge clk);
		end
	endtask

	// stop offering and wait until every result owed has been taken
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (waiting != 0)
			@(negedge clk);
	endtask

	// receiving side: random stalls, one long hold on request
	initial begin
		int stall;
		out_ready = 1'b0;
		stall = 0;
		forever begin
			@(negedge clk);
			if (long_hold) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				long_hold = 1'b0;
			end else if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				stall = idle_len();
				out_ready <= (stall == 0);
			end
		end
	end

	// run limit
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: no end after %0d cycles, %0d results owed", $time, CYCLE_LIMIT, waiting);
		$display("Simulation FAILED");
		$finish;
	end

	// stimulus and verdict
	initial begin
		int sent;
		int r;
		logic [PID_W-1:0] p;
		bit paused;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		kind         = KIND_ALLOC;
		pid          = '0;
		pages_needed = '0;
		memory_bytes = '0;
		long_hold    = 1'b0;
		no_idle      = 1'b0;
		pid_pool[0]  = '0;
		pid_pool[1]  = '1;
		for (int i = 2; i < 6; i++)
			pid_pool[i] = PID_W'($urandom);
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// free of an unknown pid on an empty table
		issue(KIND_FREE, 16'hFFFF, 7'd0, 32'd0);
		// zero pages still takes a resident entry and its bytes
		issue(KIND_ALLOC, 16'h0000, 7'd0, 32'hFFFF_FFFF);
		// whole table to one pid, then a shortage
		issue(KIND_ALLOC, 16'hFFFF, 7'd64, 32'd1);
		issue(KIND_ALLOC, 16'h0001, 7'd1, 32'd0);
		issue(KIND_QUERY, 16'hFFFF, 7'h7F, 32'hFFFF_FFFF);
		issue(KIND_FREE, 16'hFFFF, 7'h7F, 32'd0);
		// more pages than the table holds
		issue(KIND_ALLOC, 16'h0002, 7'd65, 32'h1234_5678);
		issue(KIND_UNUSED, 16'h5A5A, 7'h55, 32'hA5A5_A5A5);
		// fill the resident list, some pids more than once
		for (int i = 0; i < 15; i++)
			issue(KIND_ALLOC, 16'h0100 + 16'(i % 5), 7'd4, $urandom);
		// shortage reported ahead of a full list, then the full list alone
		issue(KIND_ALLOC, 16'h0200, 7'd5, 32'd7);
		issue(KIND_ALLOC, 16'h0200, 7'd1, 32'd7);
		issue(KIND_FREE, 16'h0100, 7'd0, 32'd0);
		drain();

		// random part; the receiver holds off at the start to back up the block
		long_hold = 1'b1;
		paused = 1'b0;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			no_idle = (sent % 300) >= 240;
			if (!paused && sent >= RANDOM_ITEMS / 2) begin
				drain();
				paused = 1'b1;
			end
			r = $urandom_range(99, 0);
			if (r < 45) begin
				// allocate, maybe query, then free the same pid
				p = ($urandom_range(1, 0) != 0) ? pick_pid() : PID_W'($urandom);
				issue(KIND_ALLOC, p, pick_need(), pick_bytes());
				sent++;
				if ($urandom_range(1, 0) != 0) begin
					issue(KIND_QUERY, p, NEED_W'($urandom), BYTES_W'($urandom));
					sent++;
				end
				issue(KIND_FREE, p, NEED_W'($urandom), BYTES_W'($urandom));
				sent++;
			end else begin
				r = $urandom_range(99, 0);
				if (r < 40)
					issue(KIND_ALLOC, pid_pool[$urandom_range(5, 0)], pick_need(), pick_bytes());
				else if (r < 65)
					issue(KIND_FREE, pick_pid(), NEED_W'($urandom), BYTES_W'($urandom));
				else if (r < 95)
					issue(KIND_QUERY, pick_pid(), NEED_W'($urandom), BYTES_W'($urandom));
				else
					issue(KIND_UNUSED, pick_pid(), NEED_W'($urandom), BYTES_W'($urandom));
				sent++;
			end
		end

		// let the last results out and watch for strays
		@(negedge clk);
		in_valid <= 1'b0;
		drain();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
